@@ rtl/abt_pkg.sv @@
// abt_pkg: action and verdict codes and field widths for the ARP binding table.
// No dependencies; imported by the channel interfaces and the top level.
package abt_pkg;

  localparam int unsigned ActionW  = 2;
  localparam int unsigned MacW     = 48;
  localparam int unsigned IpW      = 32;
  localparam int unsigned VerdictW = 3;
  localparam int unsigned CountW   = 7;
  localparam int unsigned EntryW   = MacW + IpW;

  localparam logic [ActionW-1:0] ACT_ADD    = 2'd0;
  localparam logic [ActionW-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ActionW-1:0] ACT_FLUSH  = 2'd2;

  localparam logic [VerdictW-1:0] VERDICT_EMPTY        = 3'd0;
  localparam logic [VerdictW-1:0] VERDICT_BOUND        = 3'd1;
  localparam logic [VerdictW-1:0] VERDICT_MAC_OTHER_IP = 3'd2;
  localparam logic [VerdictW-1:0] VERDICT_IP_OTHER_MAC = 3'd3;
  localparam logic [VerdictW-1:0] VERDICT_NONE         = 3'd4;

endpackage

@@ rtl/abt_if.sv @@
// abt_req_if / abt_rsp_if: valid/ready channels for request and result items.
// Depends on abt_pkg for field widths.
interface abt_req_if import abt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [MacW-1:0]    mac_address;
  logic [IpW-1:0]     ip_address;

  modport source (output valid, output action, output mac_address, output ip_address,
                  input ready);
  modport sink   (input valid, input action, input mac_address, input ip_address,
                  output ready);
endinterface

interface abt_rsp_if import abt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VerdictW-1:0] verdict;
  logic                add_accepted;
  logic [CountW-1:0]   entry_count;

  modport source (output valid, output verdict, output add_accepted, output entry_count,
                  input ready);
  modport sink   (input valid, input verdict, input add_accepted, input entry_count,
                  output ready);
endinterface

@@ rtl/arp_binding_table.sv @@
// arp_binding_table: MAC/IP binding table, entries in insertion order in one RAM.
// Add, flush, unused actions and a lookup on an empty table go straight to the result;
// a lookup on a filled table first scans from entry 0 until an entry decides it,
// one entry per cycle through the single RAM read port.
// One item in work at a time; the next is taken only after the result is issued.
// Reset clears fill count and control only.
module arp_binding_table import abt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  abt_req_if.sink   req_i,
  abt_rsp_if.source rsp_o
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(TABLE_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CntW-1:0]     fill_q, fill_d;
  logic [AddrW-1:0]    chk_q, chk_d;
  logic [MacW-1:0]     mac_q;
  logic [IpW-1:0]      ip_q;
  logic [VerdictW-1:0] pend_verdict_q, pend_verdict_d;
  logic                pend_acc_q, pend_acc_d;

  logic                out_valid_q, out_valid_d;
  logic [VerdictW-1:0] out_verdict_q;
  logic                out_acc_q;
  logic [CountW-1:0]   out_count_q;

  logic                req_fire;
  logic                out_free;
  logic                ram_we;
  logic [AddrW-1:0]    ram_raddr;
  logic [EntryW-1:0]   ram_rdata;
  logic [MacW-1:0]     rd_mac;
  logic [IpW-1:0]      rd_ip;
  logic [AddrW:0]      chk_next;
  logic                scan_last;
  logic [CntW+CountW-1:0] fill_wide;

  assign req_fire = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign out_free = !out_valid_q || rsp_o.ready;

  assign ram_we   = req_fire && (req_i.action == ACT_ADD) && (fill_q < DepthCnt);
  // Next read address: first entry on acceptance, the following one while scanning
  assign chk_next  = {1'b0, chk_q} + 1'b1;
  assign ram_raddr = (state_q == S_SCAN) ? chk_next[AddrW-1:0] : '0;
  assign rd_mac    = ram_rdata[EntryW-1:IpW];
  assign rd_ip     = ram_rdata[IpW-1:0];
  assign scan_last = ((CntW > AddrW + 1) ? CntW'(chk_next) : chk_next[CntW-1:0]) == fill_q;

  abt_ram #(
    .WIDTH (EntryW),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[AddrW-1:0]),
    .wdata_i ({req_i.mac_address, req_i.ip_address}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d        = state_q;
    fill_d         = fill_q;
    chk_d          = chk_q;
    pend_verdict_d = pend_verdict_q;
    pend_acc_d     = pend_acc_q;
    out_valid_d    = out_valid_q && !rsp_o.ready;

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          pend_verdict_d = VERDICT_EMPTY;
          pend_acc_d     = 1'b0;
          chk_d          = '0;
          state_d        = S_DONE;
          priority if (req_i.action == ACT_ADD) begin
            if (fill_q < DepthCnt) begin
              fill_d     = fill_q + 1'b1;
              pend_acc_d = 1'b1;
            end
          end else if (req_i.action == ACT_LOOKUP) begin
            if (fill_q != '0) begin
              state_d = S_SCAN;
            end
          end else if (req_i.action == ACT_FLUSH) begin
            fill_d = '0;
          end else begin
            // unused action: no state change
          end
        end
      end
      S_SCAN: begin
        // ram_rdata holds entry chk_q; the first hit decides
        priority if (rd_mac == mac_q) begin
          pend_verdict_d = (rd_ip == ip_q) ? VERDICT_BOUND : VERDICT_MAC_OTHER_IP;
          state_d        = S_DONE;
        end else if (rd_ip == ip_q) begin
          pend_verdict_d = VERDICT_IP_OTHER_MAC;
          state_d        = S_DONE;
        end else if (scan_last) begin
          pend_verdict_d = VERDICT_NONE;
          state_d        = S_DONE;
        end else begin
          chk_d = chk_next[AddrW-1:0];
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign fill_wide = {{CountW{1'b0}}, fill_q};

  always_ff @(posedge clk_i) begin
    chk_q          <= chk_d;
    pend_verdict_q <= pend_verdict_d;
    pend_acc_q     <= pend_acc_d;
    if (req_fire) begin
      mac_q <= req_i.mac_address;
      ip_q  <= req_i.ip_address;
    end
    if (state_q == S_DONE && out_free) begin
      out_verdict_q <= pend_verdict_q;
      out_acc_q     <= pend_acc_q;
      out_count_q   <= fill_wide[CountW-1:0];
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.verdict      = out_verdict_q;
  assign rsp_o.add_accepted = out_acc_q;
  assign rsp_o.entry_count  = out_count_q;

endmodule

@@ rtl/abt_ram.sv @@
// abt_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module abt_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
